FILE: hw/rtl/ps2mt_pkg.sv
// Shared types and constants for the PS/2 mouse packet tracker.
// No dependencies.
package ps2mt_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned BUTTON_W  = 3;
  localparam int unsigned CFG_IDX_W = 4;

  localparam logic [BYTE_W-1:0] SYNC_MASK     = 8'h08;
  localparam logic [BYTE_W-1:0] OVERFLOW_MASK = 8'hC0;

  localparam logic [CFG_IDX_W-1:0] CFG_START_X = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 4'd1;

  localparam logic EV_MOVE   = 1'b0;
  localparam logic EV_BUTTON = 1'b1;

  // packet queue between front and back
  localparam int unsigned Q_AW    = 1;
  localparam int unsigned Q_DEPTH = 1 << Q_AW;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              from_aux;
  } byte_t;

  typedef struct packed {
    logic               event_kind;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [BUTTON_W-1:0] button_bits;
    logic               last;
  } event_t;

  typedef struct packed {
    logic [BUTTON_W-1:0] buttons;
    logic [BYTE_W-1:0]   dx;
    logic [BYTE_W-1:0]   dy;
  } pkt_t;

  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [COORD_W-1:0]   data;
  } cfg_wr_t;

endpackage

FILE: hw/rtl/ps2mt_front.sv
// Byte front end: syncs on the header byte and assembles three-byte packets.
// Depends on ps2mt_pkg.
module ps2mt_front import ps2mt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  byte_valid,
  output logic  byte_stall,
  input  byte_t byte_req,
  input  logic  q_full,
  output logic  push,
  output pkt_t  push_pkt
);

  typedef enum logic [1:0] {
    POS_HEADER,
    POS_DX,
    POS_DY
  } pos_t;

  pos_t              byte_position;
  logic [BYTE_W-1:0] header_byte;
  logic [BYTE_W-1:0] delta_x_byte;
  logic              take;

  assign byte_stall = q_full;
  assign take       = byte_valid && !byte_stall && byte_req.from_aux;

  assign push = take && (byte_position == POS_DY) &&
                ((header_byte & OVERFLOW_MASK) == '0);
  assign push_pkt.buttons = header_byte[BUTTON_W-1:0];
  assign push_pkt.dx      = delta_x_byte;
  assign push_pkt.dy      = byte_req.rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= POS_HEADER;
    end else if (take) begin
      unique case (byte_position)
        POS_HEADER: begin
          if ((byte_req.rx_byte & SYNC_MASK) != '0) begin
            header_byte   <= byte_req.rx_byte;
            byte_position <= POS_DX;
          end
        end
        POS_DX: begin
          delta_x_byte  <= byte_req.rx_byte;
          byte_position <= POS_DY;
        end
        default: begin
          byte_position <= POS_HEADER;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/ps2mt_queue.sv
// Short packet queue between front and back ends.
// Depends on ps2mt_pkg.
module ps2mt_queue import ps2mt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  pkt_t push_pkt,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output pkt_t head_pkt
);

  pkt_t            entries [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full       = (count == (Q_AW+1)'(Q_DEPTH));
  assign head_valid = (count != '0);
  assign head_pkt   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_pkt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

FILE: hw/rtl/ps2mt_back.sv
// Back end: applies packets to cursor and buttons, emits events into an output register.
// Depends on ps2mt_pkg.
module ps2mt_back import ps2mt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_wr_t cfg_wr,
  input  logic    head_valid,
  input  pkt_t    head_pkt,
  output logic    pop,
  output logic    event_valid,
  input  logic    event_stall,
  output event_t  event_req
);

  typedef enum logic {
    PH_FIRST,
    PH_BUTTON
  } phase_t;

  phase_t              phase;
  logic [COORD_W-1:0]  cursor_x;
  logic [COORD_W-1:0]  cursor_y;
  logic [BUTTON_W-1:0] held_buttons;
  logic [COORD_W-1:0]  cursor_x_next;
  logic [COORD_W-1:0]  cursor_y_next;
  logic [COORD_W+1:0]  x_sum;
  logic [COORD_W+1:0]  y_sum;
  logic                out_free;
  logic                adv;
  logic                moved;
  logic                btn_chg;

  assign out_free = !event_valid || !event_stall;
  assign adv      = head_valid && out_free;
  assign moved    = (head_pkt.dx != '0) || (head_pkt.dy != '0);
  assign btn_chg  = (head_pkt.buttons != held_buttons);

  // clamp at zero, wrap above
  assign x_sum = {2'b00, cursor_x} + {{(COORD_W+2-BYTE_W){head_pkt.dx[BYTE_W-1]}}, head_pkt.dx};
  assign y_sum = {2'b00, cursor_y} - {{(COORD_W+2-BYTE_W){head_pkt.dy[BYTE_W-1]}}, head_pkt.dy};
  assign cursor_x_next = x_sum[COORD_W+1] ? '0 : x_sum[COORD_W-1:0];
  assign cursor_y_next = y_sum[COORD_W+1] ? '0 : y_sum[COORD_W-1:0];

  assign pop = adv && !((phase == PH_FIRST) && moved && btn_chg);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_FIRST;
      event_valid  <= 1'b0;
      cursor_x     <= '0;
      cursor_y     <= '0;
      held_buttons <= '0;
    end else begin
      if (out_free) event_valid <= 1'b0;
      if (adv) begin
        unique case (phase)
          PH_FIRST: begin
            if (moved) begin
              cursor_x              <= cursor_x_next;
              cursor_y              <= cursor_y_next;
              event_valid           <= 1'b1;
              event_req.event_kind  <= EV_MOVE;
              event_req.pos_x       <= cursor_x_next;
              event_req.pos_y       <= cursor_y_next;
              event_req.button_bits <= held_buttons;
              event_req.last        <= !btn_chg;
              if (btn_chg) phase <= PH_BUTTON;
            end else if (btn_chg) begin
              held_buttons          <= head_pkt.buttons;
              event_valid           <= 1'b1;
              event_req.event_kind  <= EV_BUTTON;
              event_req.pos_x       <= cursor_x;
              event_req.pos_y       <= cursor_y;
              event_req.button_bits <= head_pkt.buttons;
              event_req.last        <= 1'b1;
            end
          end
          PH_BUTTON: begin
            held_buttons          <= head_pkt.buttons;
            event_valid           <= 1'b1;
            event_req.event_kind  <= EV_BUTTON;
            event_req.pos_x       <= cursor_x;
            event_req.pos_y       <= cursor_y;
            event_req.button_bits <= head_pkt.buttons;
            event_req.last        <= 1'b1;
            phase                 <= PH_FIRST;
          end
          default: phase <= PH_FIRST;
        endcase
      end
      if (cfg_wr.valid) begin
        unique case (cfg_wr.index)
          CFG_START_X: cursor_x <= cfg_wr.data;
          CFG_START_Y: cursor_y <= cfg_wr.data;
          default: ;
        endcase
      end
    end
  end

  a_button_is_last: assert property (@(posedge clk) disable iff (rst)
    event_valid && (event_req.event_kind == EV_BUTTON) |-> event_req.last)
    else $error("button event not marked last");

  a_phase_has_pkt: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BUTTON) |-> head_valid)
    else $error("button phase without a queued packet");

  a_phase_holds_move: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BUTTON) |-> event_valid && (event_req.event_kind == EV_MOVE) &&
                             !event_req.last)
    else $error("button phase without pending move event");

endmodule

FILE: hw/rtl/ps2_mouse_packet_tracker.sv
// Top level of the PS/2 mouse packet tracker: front end, packet queue, back end.
// Depends on ps2mt_pkg, ps2mt_front, ps2mt_queue, ps2mt_back.
//
//   channel  handshake                  payload
//   byte     byte_valid / byte_stall    byte_req  (byte_t)
//   event    event_valid / event_stall  event_req (event_t)
//   cfg      cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One byte request per cycle while byte_stall is low; a completed packet yields
// its events one per cycle while event_stall is low (move, then button, if both).
// Synchronous active-high reset clears position, buttons and packet sync.
// byte_stall rises when the two-entry packet queue is full; out stalls back up into it.
// cfg_ready is always high.
module ps2_mouse_packet_tracker import ps2mt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_stall,
  input  byte_t                byte_req,
  output logic                 event_valid,
  input  logic                 event_stall,
  output event_t               event_req,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data
);

  logic    q_full;
  logic    push;
  pkt_t    push_pkt;
  logic    pop;
  logic    head_valid;
  pkt_t    head_pkt;
  cfg_wr_t cfg_wr;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid && cfg_ready;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  ps2mt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_req   (byte_req),
    .q_full     (q_full),
    .push       (push),
    .push_pkt   (push_pkt)
  );

  ps2mt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_pkt   (push_pkt),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_pkt   (head_pkt)
  );

  ps2mt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr      (cfg_wr),
    .head_valid  (head_valid),
    .head_pkt    (head_pkt),
    .pop         (pop),
    .event_valid (event_valid),
    .event_stall (event_stall),
    .event_req   (event_req)
  );

endmodule
